// ===== sv/sqt_pkg.sv =====
// sqt_pkg: shared types, token kinds, error codes and character helpers for the
// sql query tokenizer. No dependencies.
`timescale 1ns / 1ps

package sqt_pkg;

   localparam int VALUE_BITS_DEF    = 64;
   localparam int POSITION_BITS_DEF = 16;
   localparam int DEPTH_BITS_DEF    = 16;
   localparam int MAX_VALUE_BITS    = 64;
   localparam int MAX_POS_BITS      = 32;
   localparam int MAX_RESULTS       = 3;

   typedef logic [20:0] char_type;
   typedef logic [5:0]  kind_type;
   typedef logic [3:0]  err_type;
   typedef logic [1:0]  base_type;

   localparam kind_type K_NONE    = 6'd0;
   localparam kind_type K_END     = 6'd1;
   localparam kind_type K_ERROR   = 6'd2;
   localparam kind_type K_STRING  = 6'd3;
   localparam kind_type K_INTEGER = 6'd4;
   localparam kind_type K_FLOAT   = 6'd5;
   localparam kind_type K_IDENT   = 6'd6;
   localparam kind_type K_PERCENT = 6'd7;
   localparam kind_type K_AMP     = 6'd8;
   localparam kind_type K_LPAREN  = 6'd9;
   localparam kind_type K_RPAREN  = 6'd10;
   localparam kind_type K_LBRACK  = 6'd11;
   localparam kind_type K_RBRACK  = 6'd12;
   localparam kind_type K_STAR    = 6'd13;
   localparam kind_type K_PLUS    = 6'd14;
   localparam kind_type K_COMMA   = 6'd15;
   localparam kind_type K_DOT     = 6'd16;
   localparam kind_type K_SEMI    = 6'd17;
   localparam kind_type K_AT      = 6'd18;
   localparam kind_type K_CARET   = 6'd19;
   localparam kind_type K_EQUAL   = 6'd20;
   localparam kind_type K_TILDE   = 6'd21;
   localparam kind_type K_HASH    = 6'd22;
   localparam kind_type K_COLON   = 6'd23;
   localparam kind_type K_SCOPE   = 6'd24;
   localparam kind_type K_DIV     = 6'd25;
   localparam kind_type K_MINUS   = 6'd26;
   localparam kind_type K_LT      = 6'd27;
   localparam kind_type K_LE      = 6'd28;
   localparam kind_type K_SHL     = 6'd29;
   localparam kind_type K_NE      = 6'd30;
   localparam kind_type K_GT      = 6'd31;
   localparam kind_type K_GE      = 6'd32;
   localparam kind_type K_SHR     = 6'd33;
   localparam kind_type K_SQRT    = 6'd34;
   localparam kind_type K_CBRT    = 6'd35;
   localparam kind_type K_CONCAT  = 6'd36;
   localparam kind_type K_BITOR   = 6'd37;

   localparam err_type ERR_NONE          = 4'd0;
   localparam err_type ERR_OPEN_COMMENT  = 4'd1;
   localparam err_type ERR_OPEN_STRING   = 4'd2;
   localparam err_type ERR_NEWLINE       = 4'd3;
   localparam err_type ERR_BACKSLASH     = 4'd4;
   localparam err_type ERR_BIN_DIGIT     = 4'd5;
   localparam err_type ERR_OCT_DIGIT     = 4'd6;
   localparam err_type ERR_NO_QUOTE      = 4'd7;
   localparam err_type ERR_NO_DIGITS     = 4'd8;
   localparam err_type ERR_UNEXPECTED    = 4'd9;
   localparam err_type ERR_DEEP_COMMENT  = 4'd10;
   localparam err_type ERR_EMPTY_EXP     = 4'd11;

   localparam base_type BASE_DEC = 2'd0;
   localparam base_type BASE_BIN = 2'd1;
   localparam base_type BASE_OCT = 2'd2;
   localparam base_type BASE_HEX = 2'd3;

   typedef enum logic [4:0] {
      M_START, M_ERROR, M_COLON, M_SLASH, M_MINUS, M_LT, M_GT, M_BAR, M_BAR2,
      M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH, M_LINE, M_HASH, M_HASH_BOL,
      M_STRING, M_STRING_QUOTE, M_PREFIX, M_IDENT, M_ZERO, M_BIN, M_OCT,
      M_HEX, M_DEC, M_FRAC, M_EXP_START, M_EXP_SIGN, M_EXP_DIGITS
   } mode_type;

   typedef struct packed {
      kind_type                  kind;
      logic                      is_text;
      char_type                  text_char;
      logic                      done;
      logic [MAX_VALUE_BITS-1:0] value;
      logic                      overflow;
      logic [MAX_POS_BITS-1:0]   line;
      logic [MAX_POS_BITS-1:0]   column;
      err_type                   err;
   } result_type;

   function automatic logic is_digit(char_type c);
      return c >= 21'("0") && c <= 21'("9");
   endfunction

   function automatic logic is_alpha(char_type c);
      return (c >= 21'("a") && c <= 21'("z")) || (c >= 21'("A") && c <= 21'("Z")) ||
             c == 21'("_");
   endfunction

   function automatic logic is_hex(char_type c);
      return is_digit(c) || (c >= 21'("a") && c <= 21'("f")) ||
             (c >= 21'("A") && c <= 21'("F"));
   endfunction

   function automatic logic [3:0] hex_val(char_type c);
      return is_digit(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
   endfunction

   function automatic logic is_space(char_type c);
      return c == 21'h20 || c == 21'h0a || c == 21'h09 || c == 21'h0c || c == 21'h0b;
   endfunction

   // single character operators, K_NONE when not one
   function automatic kind_type op_kind(char_type c);
      kind_type k;
      k = K_NONE;
      if (c[20:8] == '0) begin
         case (c[7:0])
            8'h25:   k = K_PERCENT;
            8'h26:   k = K_AMP;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5b:   k = K_LBRACK;
            8'h5d:   k = K_RBRACK;
            8'h2a:   k = K_STAR;
            8'h2b:   k = K_PLUS;
            8'h2c:   k = K_COMMA;
            8'h2e:   k = K_DOT;
            8'h3b:   k = K_SEMI;
            8'h40:   k = K_AT;
            8'h5e:   k = K_CARET;
            8'h3d:   k = K_EQUAL;
            8'h7e:   k = K_TILDE;
            default: k = K_NONE;
         endcase
      end
      return k;
   endfunction

endpackage

// ===== sv/sqt_core.sv =====
// sqt_core: lexer state registers and the single-pass step logic that turns one
// character beat into up to three results. Depends on sqt_pkg.
`timescale 1ns / 1ps

module sqt_core import sqt_pkg::*; #(
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  char_type               char_code,
   input  logic                   end_of_stream,
   output result_type [2:0]       res,
   output logic [1:0]             res_count
);

   localparam int VB = VALUE_BITS;
   localparam int PB = POSITION_BITS;
   localparam int DB = DEPTH_BITS;

   mode_type        mode_ff, mode_in;
   logic [VB-1:0]   acc_ff, acc_in;
   logic            ovf_ff, ovf_in;
   logic            dseen_ff, dseen_in;
   logic            quo_ff, quo_in;
   logic            esc_ff, esc_in;
   logic [DB-1:0]   dep_ff, dep_in;
   char_type        held_ff, held_in;
   logic [PB-1:0]   ln_ff, ln_in;
   logic [PB-1:0]   cl_ff, cl_in;
   logic [PB-1:0]   tl_ff, tl_in;
   logic [PB-1:0]   tc_ff, tc_in;

   function automatic result_type mk(kind_type kind, logic txt, char_type ch, logic done,
                                     logic [VB-1:0] val, logic ovf, logic [PB-1:0] line,
                                     logic [PB-1:0] col, err_type err);
      result_type r;
      r.kind      = kind;
      r.is_text   = txt;
      r.text_char = ch;
      r.done      = done;
      r.value     = MAX_VALUE_BITS'(val);
      r.overflow  = ovf;
      r.line      = MAX_POS_BITS'(line);
      r.column    = MAX_POS_BITS'(col);
      r.err       = err;
      return r;
   endfunction

   // value * base + digit, saturating; top bit flags overflow
   function automatic logic [VB:0] acc_step(logic [VB-1:0] val, base_type base,
                                            logic [3:0] d);
      logic [VB+3:0] w;
      logic [VB+3:0] p;
      w = (VB+4)'(val);
      case (base)
         BASE_DEC: p = (w << 3) + (w << 1) + (VB+4)'(d);
         BASE_BIN: p = (w << 1) + (VB+4)'(d);
         BASE_OCT: p = (w << 3) + (VB+4)'(d);
         BASE_HEX: p = (w << 4) + (VB+4)'(d);
         default:  p = w;
      endcase
      if (|p[VB+3:VB]) return {1'b1, {VB{1'b1}}};
      return {1'b0, p[VB-1:0]};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_START;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         dseen_ff <= 1'b0;
         quo_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         dep_ff   <= '0;
         held_ff  <= '0;
         ln_ff    <= PB'(1);
         cl_ff    <= PB'(1);
         tl_ff    <= '0;
         tc_ff    <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         dseen_ff <= dseen_in;
         quo_ff   <= quo_in;
         esc_ff   <= esc_in;
         dep_ff   <= dep_in;
         held_ff  <= held_in;
         ln_ff    <= ln_in;
         cl_ff    <= cl_in;
         tl_ff    <= tl_in;
         tc_ff    <= tc_in;
      end
   end

   always_comb begin
      char_type      c;
      char_type      h;
      logic          do_start;
      logic          do_acc;
      base_type      base;
      logic [3:0]    dig;
      logic [VB:0]   acc_new;
      kind_type      ok;
      logic [1:0]    n;
      result_type [2:0] r;

      c        = char_code;
      h        = '0;
      do_start = 1'b0;
      do_acc   = 1'b0;
      base     = BASE_DEC;
      dig      = '0;
      acc_new  = '0;
      ok       = K_NONE;
      n        = 2'd0;
      r        = '0;

      mode_in  = mode_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      dseen_in = dseen_ff;
      quo_in   = quo_ff;
      esc_in   = esc_ff;
      dep_in   = dep_ff;
      held_in  = held_ff;
      ln_in    = ln_ff;
      cl_in    = cl_ff;
      tl_in    = tl_ff;
      tc_in    = tc_ff;

      if (end_of_stream) begin
         case (mode_ff)
            M_COLON: begin
               r[n] = mk(K_COLON, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_SLASH: begin
               r[n] = mk(K_DIV, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_MINUS: begin
               r[n] = mk(K_MINUS, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_LT: begin
               r[n] = mk(K_LT, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_GT: begin
               r[n] = mk(K_GT, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_BAR: begin
               r[n] = mk(K_BITOR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_BAR2: begin
               r[n] = mk(K_CONCAT, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH: begin
               r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_OPEN_COMMENT);
               n = n + 2'd1;
            end
            M_STRING: begin
               r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_OPEN_STRING);
               n = n + 2'd1;
            end
            M_STRING_QUOTE: begin
               r[n] = mk(K_STRING, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_PREFIX: begin
               r[n] = mk(K_IDENT, 1'b1, held_ff, 1'b0, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
               r[n] = mk(K_IDENT, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_IDENT: begin
               r[n] = mk(K_IDENT, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_ZERO, M_DEC: begin
               r[n] = mk(K_INTEGER, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_BIN, M_OCT, M_HEX: begin
               if (quo_ff) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NO_QUOTE);
               end else if (!dseen_ff) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_NO_DIGITS);
               end else begin
                  r[n] = mk(K_INTEGER, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_ff, tc_ff,
                            ERR_NONE);
               end
               n = n + 2'd1;
            end
            M_FRAC, M_EXP_DIGITS: begin
               r[n] = mk(K_FLOAT, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_ff, tc_ff, ERR_NONE);
               n = n + 2'd1;
            end
            M_EXP_START, M_EXP_SIGN: begin
               r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_ff, tc_ff, ERR_EMPTY_EXP);
               n = n + 2'd1;
            end
            default: begin
            end
         endcase
         r[n] = mk(K_END, 1'b0, '0, 1'b1, '0, 1'b0, ln_ff, cl_ff, ERR_NONE);
         n = n + 2'd1;
         mode_in  = M_START;
         acc_in   = '0;
         ovf_in   = 1'b0;
         dseen_in = 1'b0;
         quo_in   = 1'b0;
         esc_in   = 1'b0;
         dep_in   = '0;
         held_in  = '0;
         ln_in    = PB'(1);
         cl_in    = PB'(1);
         tl_in    = '0;
         tc_in    = '0;
      end else begin
         case (mode_ff)
            M_START: do_start = 1'b1;
            M_COLON: begin
               if (c == 21'(":")) begin
                  r[n] = mk(K_SCOPE, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else begin
                  r[n] = mk(K_COLON, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_SLASH: begin
               if (c == 21'("*")) begin
                  dep_in  = DB'(1);
                  mode_in = M_BLOCK;
               end else begin
                  r[n] = mk(K_DIV, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_MINUS: begin
               if (c == 21'("-")) begin
                  mode_in = M_LINE;
               end else begin
                  r[n] = mk(K_MINUS, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_LT: begin
               if (c == 21'("=")) begin
                  r[n] = mk(K_LE, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else if (c == 21'("<")) begin
                  r[n] = mk(K_SHL, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else if (c == 21'(">")) begin
                  r[n] = mk(K_NE, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else begin
                  r[n] = mk(K_LT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_GT: begin
               if (c == 21'("=")) begin
                  r[n] = mk(K_GE, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else if (c == 21'(">")) begin
                  r[n] = mk(K_SHR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else begin
                  r[n] = mk(K_GT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_BAR: begin
               if (c == 21'("/")) begin
                  r[n] = mk(K_SQRT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else if (c == 21'("|")) begin
                  mode_in = M_BAR2;
               end else begin
                  r[n] = mk(K_BITOR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_BAR2: begin
               if (c == 21'("/")) begin
                  r[n] = mk(K_CBRT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_START;
               end else begin
                  r[n] = mk(K_CONCAT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH: begin
               if (mode_ff == M_BLOCK_STAR && c == 21'("/")) begin
                  dep_in  = dep_ff - DB'(1);
                  mode_in = (dep_in == '0) ? M_START : M_BLOCK;
               end else if (mode_ff == M_BLOCK_SLASH && c == 21'("*")) begin
                  if (&dep_ff) begin
                     r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in,
                               ERR_DEEP_COMMENT);
                     n = n + 2'd1;
                     mode_in = M_ERROR;
                  end else begin
                     dep_in  = dep_ff + DB'(1);
                     mode_in = M_BLOCK;
                  end
               end else if (c == 21'("*")) begin
                  mode_in = M_BLOCK_STAR;
               end else if (c == 21'("/")) begin
                  mode_in = M_BLOCK_SLASH;
               end else begin
                  mode_in = M_BLOCK;
               end
            end
            M_LINE: begin
               if (c == 21'h0a) mode_in = M_START;
            end
            M_HASH: begin
               if (c == 21'h0a) mode_in = M_HASH_BOL;
            end
            M_HASH_BOL: begin
               if (c == 21'("#")) mode_in = M_HASH;
               else do_start = 1'b1;
            end
            M_STRING: begin
               if (c == 21'h27) begin
                  mode_in = M_STRING_QUOTE;
               end else if (c == 21'h0a) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NEWLINE);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end else if (esc_ff && c == 21'h5c) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_BACKSLASH);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end else begin
                  r[n] = mk(K_STRING, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
               end
            end
            M_STRING_QUOTE: begin
               if (c == 21'h27) begin
                  r[n] = mk(K_STRING, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_STRING;
               end else begin
                  r[n] = mk(K_STRING, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_PREFIX: begin
               h = held_ff | 21'h20;
               if (c == 21'h27) begin
                  acc_in   = '0;
                  ovf_in   = 1'b0;
                  dseen_in = 1'b0;
                  quo_in   = 1'b1;
                  if (h == 21'("b")) begin
                     mode_in = M_BIN;
                  end else if (h == 21'("o")) begin
                     mode_in = M_OCT;
                  end else if (h == 21'("x")) begin
                     mode_in = M_HEX;
                  end else begin
                     acc_in   = acc_ff;
                     ovf_in   = ovf_ff;
                     dseen_in = dseen_ff;
                     quo_in   = quo_ff;
                     mode_in  = M_STRING;
                     esc_in   = 1'b1;
                  end
               end else begin
                  r[n] = mk(K_IDENT, 1'b1, held_ff, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_IDENT;
                  if (is_alpha(c) || is_digit(c)) begin
                     r[n] = mk(K_IDENT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                     n = n + 2'd1;
                  end else begin
                     r[n] = mk(K_IDENT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                     n = n + 2'd1;
                     do_start = 1'b1;
                  end
               end
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  r[n] = mk(K_IDENT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  r[n] = mk(K_IDENT, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_ZERO, M_DEC: begin
               h = c | 21'h20;
               if (mode_ff == M_ZERO && h == 21'("b")) begin
                  mode_in = M_BIN;
               end else if (mode_ff == M_ZERO && h == 21'("x")) begin
                  mode_in = M_HEX;
               end else if (mode_ff == M_ZERO && h == 21'("o")) begin
                  mode_in = M_OCT;
               end else begin
                  if (mode_ff == M_ZERO) begin
                     mode_in  = M_DEC;
                     dseen_in = 1'b1;
                  end
                  if (is_digit(c)) begin
                     do_acc = 1'b1;
                     base   = BASE_DEC;
                     dig    = c[3:0];
                  end else if (c == 21'(".")) begin
                     r[n] = mk(K_FLOAT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                     n = n + 2'd1;
                     mode_in = M_FRAC;
                  end else begin
                     r[n] = mk(K_INTEGER, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_in, tc_in,
                               ERR_NONE);
                     n = n + 2'd1;
                     do_start = 1'b1;
                  end
               end
            end
            M_BIN, M_OCT, M_HEX: begin
               if (mode_ff == M_BIN && (c == 21'("0") || c == 21'("1"))) begin
                  do_acc = 1'b1;
                  base   = BASE_BIN;
                  dig    = c[3:0];
               end else if (mode_ff == M_BIN && c >= 21'("2") && c <= 21'("9")) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_BIN_DIGIT);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end else if (mode_ff == M_OCT && c >= 21'("0") && c <= 21'("7")) begin
                  do_acc = 1'b1;
                  base   = BASE_OCT;
                  dig    = c[3:0];
               end else if (mode_ff == M_OCT && (c == 21'("8") || c == 21'("9"))) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_OCT_DIGIT);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end else if (mode_ff == M_HEX && is_hex(c)) begin
                  do_acc = 1'b1;
                  base   = BASE_HEX;
                  dig    = hex_val(c);
               end else if (quo_ff) begin
                  if (c != 21'h27) begin
                     r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in,
                               ERR_NO_QUOTE);
                     mode_in = M_ERROR;
                  end else if (!dseen_ff) begin
                     r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in,
                               ERR_NO_DIGITS);
                     mode_in = M_ERROR;
                  end else begin
                     r[n] = mk(K_INTEGER, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_in, tc_in,
                               ERR_NONE);
                     mode_in = M_START;
                  end
                  n = n + 2'd1;
               end else if (!dseen_ff) begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NO_DIGITS);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end else begin
                  r[n] = mk(K_INTEGER, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_in, tc_in,
                            ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_FRAC: begin
               if (is_digit(c)) begin
                  r[n] = mk(K_FLOAT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
               end else if (c == 21'("e") || c == 21'("E")) begin
                  r[n] = mk(K_FLOAT, 1'b1, 21'("e"), 1'b0, '0, 1'b0, tl_in, tc_in,
                            ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXP_START;
               end else begin
                  r[n] = mk(K_FLOAT, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            M_EXP_START, M_EXP_SIGN: begin
               if (mode_ff == M_EXP_START && (c == 21'("+") || c == 21'("-"))) begin
                  r[n] = mk(K_FLOAT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXP_SIGN;
               end else if (is_digit(c)) begin
                  r[n] = mk(K_FLOAT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = M_EXP_DIGITS;
               end else begin
                  r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_EMPTY_EXP);
                  n = n + 2'd1;
                  mode_in = M_ERROR;
               end
            end
            M_EXP_DIGITS: begin
               if (is_digit(c)) begin
                  r[n] = mk(K_FLOAT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  r[n] = mk(K_FLOAT, 1'b0, '0, 1'b1, acc_ff, ovf_ff, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
                  do_start = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // start of a new token
         if (do_start) begin
            tl_in   = ln_ff;
            tc_in   = cl_ff;
            mode_in = M_START;
            ok      = op_kind(c);
            if (is_space(c)) begin
               mode_in = M_START;
            end else if (ok != K_NONE) begin
               r[n] = mk(ok, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
               n = n + 2'd1;
            end else if (c == 21'(":")) begin
               mode_in = M_COLON;
            end else if (c == 21'("/")) begin
               mode_in = M_SLASH;
            end else if (c == 21'("-")) begin
               mode_in = M_MINUS;
            end else if (c == 21'("<")) begin
               mode_in = M_LT;
            end else if (c == 21'(">")) begin
               mode_in = M_GT;
            end else if (c == 21'("|")) begin
               mode_in = M_BAR;
            end else if (c == 21'("#")) begin
               if (ln_ff == PB'(1) && cl_ff == PB'(1)) begin
                  mode_in = M_HASH;
               end else begin
                  r[n] = mk(K_HASH, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_NONE);
                  n = n + 2'd1;
               end
            end else if (c == 21'h27) begin
               mode_in = M_STRING;
               esc_in  = 1'b0;
            end else if (c == 21'("0")) begin
               mode_in  = M_ZERO;
               acc_in   = '0;
               ovf_in   = 1'b0;
               dseen_in = 1'b0;
               quo_in   = 1'b0;
            end else if ((c | 21'h20) == 21'("b") || (c | 21'h20) == 21'("e") ||
                         (c | 21'h20) == 21'("o") || (c | 21'h20) == 21'("x")) begin
               held_in = c;
               mode_in = M_PREFIX;
            end else if (is_digit(c)) begin
               mode_in  = M_DEC;
               acc_in   = VB'(c[3:0]);
               ovf_in   = 1'b0;
               dseen_in = 1'b1;
               quo_in   = 1'b0;
            end else if (is_alpha(c)) begin
               r[n] = mk(K_IDENT, 1'b1, c, 1'b0, '0, 1'b0, tl_in, tc_in, ERR_NONE);
               n = n + 2'd1;
               mode_in = M_IDENT;
            end else begin
               r[n] = mk(K_ERROR, 1'b0, '0, 1'b1, '0, 1'b0, tl_in, tc_in, ERR_UNEXPECTED);
               n = n + 2'd1;
               mode_in = M_ERROR;
            end
         end

         if (do_acc) begin
            acc_new  = acc_step(acc_ff, base, dig);
            acc_in   = acc_new[VB-1:0];
            ovf_in   = ovf_ff | acc_new[VB];
            dseen_in = 1'b1;
         end

         // position counters
         if (c == 21'h0a) begin
            if (!(&ln_ff)) ln_in = ln_ff + PB'(1);
            cl_in = PB'(1);
         end else if (!(&cl_ff)) begin
            cl_in = cl_ff + PB'(1);
         end
      end

      res       = r;
      res_count = n;
   end

endmodule

// ===== sv/sqt_rsp_buf.sv =====
// sqt_rsp_buf: result register holding up to three results of one step and
// handing them out one beat at a time. Depends on sqt_pkg.
`timescale 1ns / 1ps

module sqt_rsp_buf import sqt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  result_type [2:0] load_res,
   input  logic [1:0]       load_count,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output result_type       rsp_res,
   output logic             rsp_last,
   output logic             free
);

   result_type [2:0] slot_ff;
   logic [1:0]       count_ff, count_in;
   logic [1:0]       idx_ff, idx_in;
   logic             pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_res   = slot_ff[idx_ff];
   assign rsp_last  = (idx_ff == count_ff - 2'd1);
   assign pop       = rsp_valid && !rsp_stall;
   assign free      = !rsp_valid || (pop && rsp_last);

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = load_count;
         idx_in   = 2'd0;
      end else if (pop) begin
         if (rsp_last) begin
            count_in = 2'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_res;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff < count_ff)
      else $error("result index beyond count");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("results loaded over pending beats");
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> idx_ff == 2'd0 && count_ff == $past(load_count))
      else $error("loaded results not presented from the first");
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      pop && rsp_last && !load |=> !rsp_valid)
      else $error("buffer not empty after last beat");
`endif

endmodule

// ===== sv/sql_query_tokenizer.sv =====
// sql_query_tokenizer: top level with input register, step logic and result
// buffer. Depends on sqt_pkg, sqt_core and sqt_rsp_buf.
`timescale 1ns / 1ps

// One character (or end-of-stream) is taken per beat and handled by the step
// logic between the input register and the result buffer, so a new character
// can be accepted while the results of the last one are handed out. A character
// makes zero to three results; the result port moves one per cycle unless
// rsp_stall holds it, so sustained input rate is one character per cycle when
// each makes at most one result and the port is not stalled, and otherwise is
// set by the result port.
module sql_query_tokenizer import sqt_pkg::*; #(
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [20:0]              req_char_code,
   input  logic                     req_end_of_stream,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_token_kind,
   output logic                     rsp_is_text,
   output logic [20:0]              rsp_text_char,
   output logic                     rsp_token_done,
   output logic [VALUE_BITS-1:0]    rsp_int_value,
   output logic                     rsp_value_overflow,
   output logic [POSITION_BITS-1:0] rsp_start_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [3:0]               rsp_error_code,
   output logic                     rsp_last
);

   logic             in_vld_ff, in_vld_in;
   char_type         in_char_ff;
   logic             in_eos_ff;
   logic             fire;
   logic             buf_free;
   result_type [2:0] step_res;
   logic [1:0]       step_count;
   result_type       out_res;

   assign fire      = in_vld_ff && buf_free;
   assign req_stall = in_vld_ff && !buf_free;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   sqt_core #(
      .VALUE_BITS    (VALUE_BITS),
      .POSITION_BITS (POSITION_BITS),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .char_code     (in_char_ff),
      .end_of_stream (in_eos_ff),
      .res           (step_res),
      .res_count     (step_count)
   );

   sqt_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .load_res   (step_res),
      .load_count (step_count),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_res    (out_res),
      .rsp_last   (rsp_last),
      .free       (buf_free)
   );

   assign rsp_token_kind     = out_res.kind;
   assign rsp_is_text        = out_res.is_text;
   assign rsp_text_char      = out_res.text_char;
   assign rsp_token_done     = out_res.done;
   assign rsp_int_value      = out_res.value[VALUE_BITS-1:0];
   assign rsp_value_overflow = out_res.overflow;
   assign rsp_start_line     = out_res.line[POSITION_BITS-1:0];
   assign rsp_start_column   = out_res.column[POSITION_BITS-1:0];
   assign rsp_error_code     = out_res.err;

endmodule

// ===== sim/sqt_token_checker.sv =====
// sqt_token_checker: watches both channels of the sql query tokenizer, predicts
// every result beat from the accepted characters and compares them in order.
// Depends on sqt_pkg for token kinds, error codes and lexer modes.
`timescale 1ns / 1ps

module sqt_token_checker import sqt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [20:0] req_char_code,
   input  logic        req_end_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_token_kind,
   input  logic        rsp_is_text,
   input  logic [20:0] rsp_text_char,
   input  logic        rsp_token_done,
   input  logic [63:0] rsp_int_value,
   input  logic        rsp_value_overflow,
   input  logic [15:0] rsp_start_line,
   input  logic [15:0] rsp_start_column,
   input  logic [3:0]  rsp_error_code,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [5:0]  kind;
      logic        txt;
      logic [20:0] ch;
      logic        done;
      logic [63:0] val;
      logic        ovf;
      logic [15:0] line;
      logic [15:0] col;
      logic [3:0]  err;
      logic        last;
   } tok_beat_type;

   tok_beat_type token_q[$];
   tok_beat_type step_q[$];

   mode_type    md;
   logic [63:0] acc;
   logic        aovf, dseen, quoted, esc;
   logic [15:0] depth;
   logic [20:0] held;
   logic [15:0] ln, col, tl, tc;

   task automatic lex_reset();
      md = M_START; acc = '0; aovf = 0; dseen = 0; quoted = 0; esc = 0;
      depth = '0; held = '0; ln = 16'd1; col = 16'd1; tl = '0; tc = '0;
   endtask

   task automatic put(logic [5:0] k, logic t, logic [20:0] ch, logic d, logic [63:0] v,
                      logic o, logic [15:0] l, logic [15:0] c, logic [3:0] e);
      tok_beat_type b;
      b.kind = k; b.txt = t; b.ch = ch; b.done = d; b.val = v; b.ovf = o;
      b.line = l; b.col = c; b.err = e; b.last = 0;
      if (step_q.size() < 3) step_q.push_back(b);
   endtask

   task automatic emit_text(logic [5:0] k, logic [20:0] ch);
      put(k, 1, ch, 0, '0, 0, tl, tc, ERR_NONE);
   endtask

   task automatic emit_done(logic [5:0] k);
      put(k, 0, '0, 1, '0, 0, tl, tc, ERR_NONE);
   endtask

   task automatic emit_number(logic [5:0] k);
      put(k, 0, '0, 1, acc, aovf, tl, tc, ERR_NONE);
   endtask

   task automatic emit_error(logic [3:0] e);
      put(K_ERROR, 0, '0, 1, '0, 0, tl, tc, e);
      md = M_ERROR;
   endtask

   task automatic begin_number(mode_type m, logic q);
      md = m; acc = '0; aovf = 0; dseen = 0; quoted = q;
   endtask

   task automatic add_digit(logic [63:0] base, logic [63:0] d);
      dseen = 1;
      if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / base) begin
         acc = 64'hFFFF_FFFF_FFFF_FFFF;
         aovf = 1;
      end else begin
         acc = acc * base + d;
      end
   endtask

   function automatic logic dig(logic [20:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic alpha(logic [20:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   task automatic start_token(logic [20:0] c);
      string ops;
      ops = "%&()[]*+,.;@^=~";
      tl = ln; tc = col; md = M_START;
      if (c == " " || c == 21'h0a || c == 21'h09 || c == 21'h0c || c == 21'h0b) return;
      for (int i = 0; i < ops.len(); i++)
         if (c == ops[i]) begin
            emit_done(K_PERCENT + 6'(i));
            return;
         end
      if (c == ":") md = M_COLON;
      else if (c == "/") md = M_SLASH;
      else if (c == "-") md = M_MINUS;
      else if (c == "<") md = M_LT;
      else if (c == ">") md = M_GT;
      else if (c == "|") md = M_BAR;
      else if (c == "#") begin
         if (ln == 1 && col == 1) md = M_HASH;
         else emit_done(K_HASH);
      end else if (c == "'") begin
         md = M_STRING; esc = 0;
      end else if (c == "0") begin
         begin_number(M_ZERO, 0);
      end else if (c == "b" || c == "B" || c == "e" || c == "E" || c == "o" || c == "O" ||
                   c == "x" || c == "X") begin
         held = c; md = M_PREFIX;
      end else if (dig(c)) begin
         begin_number(M_DEC, 0);
         add_digit(10, 64'(c - "0"));
      end else if (alpha(c)) begin
         emit_text(K_IDENT, c);
         md = M_IDENT;
      end else begin
         emit_error(ERR_UNEXPECTED);
      end
   endtask

   task automatic finish_then(logic [5:0] k, logic [20:0] c);
      emit_done(k);
      start_token(c);
   endtask

   task automatic number_then(logic [5:0] k, logic [20:0] c);
      emit_number(k);
      start_token(c);
   endtask

   task automatic ident_char(logic [20:0] c);
      if (alpha(c) || dig(c)) emit_text(K_IDENT, c);
      else finish_then(K_IDENT, c);
   endtask

   task automatic dec_char(logic [20:0] c);
      if (dig(c)) add_digit(10, 64'(c - "0"));
      else if (c == ".") begin
         emit_text(K_FLOAT, "."); md = M_FRAC;
      end else number_then(K_INTEGER, c);
   endtask

   task automatic radix_end(logic [20:0] c);
      if (quoted) begin
         if (c != "'") emit_error(ERR_NO_QUOTE);
         else if (!dseen) emit_error(ERR_NO_DIGITS);
         else begin
            emit_number(K_INTEGER); md = M_START;
         end
      end else if (!dseen) emit_error(ERR_NO_DIGITS);
      else number_then(K_INTEGER, c);
   endtask

   task automatic block_char(logic [20:0] c);
      if (md == M_BLOCK_STAR && c == "/") begin
         depth = depth - 1;
         md = (depth == 0) ? M_START : M_BLOCK;
      end else if (md == M_BLOCK_SLASH && c == "*") begin
         if (depth == 16'hFFFF) emit_error(ERR_DEEP_COMMENT);
         else begin
            depth = depth + 1; md = M_BLOCK;
         end
      end else if (c == "*") md = M_BLOCK_STAR;
      else if (c == "/") md = M_BLOCK_SLASH;
      else md = M_BLOCK;
   endtask

   task automatic take_char(logic [20:0] c);
      logic [20:0] h;
      case (md)
         M_START: start_token(c);
         M_COLON: if (c == ":") begin
            emit_done(K_SCOPE); md = M_START;
         end else finish_then(K_COLON, c);
         M_SLASH: if (c == "*") begin
            depth = 1; md = M_BLOCK;
         end else finish_then(K_DIV, c);
         M_MINUS: if (c == "-") md = M_LINE; else finish_then(K_MINUS, c);
         M_LT: begin
            if (c == "=") begin emit_done(K_LE); md = M_START; end
            else if (c == "<") begin emit_done(K_SHL); md = M_START; end
            else if (c == ">") begin emit_done(K_NE); md = M_START; end
            else finish_then(K_LT, c);
         end
         M_GT: begin
            if (c == "=") begin emit_done(K_GE); md = M_START; end
            else if (c == ">") begin emit_done(K_SHR); md = M_START; end
            else finish_then(K_GT, c);
         end
         M_BAR: begin
            if (c == "/") begin emit_done(K_SQRT); md = M_START; end
            else if (c == "|") md = M_BAR2;
            else finish_then(K_BITOR, c);
         end
         M_BAR2: if (c == "/") begin
            emit_done(K_CBRT); md = M_START;
         end else finish_then(K_CONCAT, c);
         M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH: block_char(c);
         M_LINE: if (c == 21'h0a) md = M_START;
         M_HASH: if (c == 21'h0a) md = M_HASH_BOL;
         M_HASH_BOL: if (c == "#") md = M_HASH; else start_token(c);
         M_STRING: begin
            if (c == "'") md = M_STRING_QUOTE;
            else if (c == 21'h0a) emit_error(ERR_NEWLINE);
            else if (esc && c == "\\") emit_error(ERR_BACKSLASH);
            else emit_text(K_STRING, c);
         end
         M_STRING_QUOTE: if (c == "'") begin
            emit_text(K_STRING, "'"); md = M_STRING;
         end else finish_then(K_STRING, c);
         M_PREFIX: begin
            h = held | 21'h20;
            if (c == "'") begin
               if (h == "b") begin_number(M_BIN, 1);
               else if (h == "o") begin_number(M_OCT, 1);
               else if (h == "x") begin_number(M_HEX, 1);
               else begin
                  md = M_STRING; esc = 1;
               end
            end else begin
               emit_text(K_IDENT, held);
               md = M_IDENT;
               ident_char(c);
            end
         end
         M_IDENT: ident_char(c);
         M_ZERO: begin
            h = c | 21'h20;
            if (h == "b") md = M_BIN;
            else if (h == "x") md = M_HEX;
            else if (h == "o") md = M_OCT;
            else begin
               md = M_DEC; dseen = 1; dec_char(c);
            end
         end
         M_DEC: dec_char(c);
         M_BIN: begin
            if (c == "0" || c == "1") add_digit(2, 64'(c - "0"));
            else if (c >= "2" && c <= "9") emit_error(ERR_BIN_DIGIT);
            else radix_end(c);
         end
         M_OCT: begin
            if (c >= "0" && c <= "7") add_digit(8, 64'(c - "0"));
            else if (c == "8" || c == "9") emit_error(ERR_OCT_DIGIT);
            else radix_end(c);
         end
         M_HEX: begin
            if (dig(c)) add_digit(16, 64'(c - "0"));
            else if (c >= "a" && c <= "f") add_digit(16, 64'(c - "a" + 10));
            else if (c >= "A" && c <= "F") add_digit(16, 64'(c - "A" + 10));
            else radix_end(c);
         end
         M_FRAC: begin
            if (dig(c)) emit_text(K_FLOAT, c);
            else if (c == "e" || c == "E") begin
               emit_text(K_FLOAT, "e"); md = M_EXP_START;
            end else number_then(K_FLOAT, c);
         end
         M_EXP_START: begin
            if (c == "+" || c == "-") begin
               emit_text(K_FLOAT, c); md = M_EXP_SIGN;
            end else if (dig(c)) begin
               emit_text(K_FLOAT, c); md = M_EXP_DIGITS;
            end else emit_error(ERR_EMPTY_EXP);
         end
         M_EXP_SIGN: if (dig(c)) begin
            emit_text(K_FLOAT, c); md = M_EXP_DIGITS;
         end else emit_error(ERR_EMPTY_EXP);
         M_EXP_DIGITS: if (dig(c)) emit_text(K_FLOAT, c); else number_then(K_FLOAT, c);
         default: ;
      endcase
   endtask

   task automatic close_script();
      case (md)
         M_COLON: emit_done(K_COLON);
         M_SLASH: emit_done(K_DIV);
         M_MINUS: emit_done(K_MINUS);
         M_LT: emit_done(K_LT);
         M_GT: emit_done(K_GT);
         M_BAR: emit_done(K_BITOR);
         M_BAR2: emit_done(K_CONCAT);
         M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH: emit_error(ERR_OPEN_COMMENT);
         M_STRING: emit_error(ERR_OPEN_STRING);
         M_STRING_QUOTE: emit_done(K_STRING);
         M_PREFIX: begin
            emit_text(K_IDENT, held); emit_done(K_IDENT);
         end
         M_IDENT: emit_done(K_IDENT);
         M_ZERO, M_DEC: emit_number(K_INTEGER);
         M_BIN, M_OCT, M_HEX: begin
            if (quoted) emit_error(ERR_NO_QUOTE);
            else if (!dseen) emit_error(ERR_NO_DIGITS);
            else emit_number(K_INTEGER);
         end
         M_FRAC, M_EXP_DIGITS: emit_number(K_FLOAT);
         M_EXP_START, M_EXP_SIGN: emit_error(ERR_EMPTY_EXP);
         default: ;
      endcase
   endtask

   task automatic predict_beat(logic [20:0] c, logic eos);
      step_q.delete();
      if (eos) begin
         close_script();
         put(K_END, 0, '0, 1, '0, 0, ln, col, ERR_NONE);
         lex_reset();
      end else begin
         take_char(c);
         if (c == 21'h0a) begin
            if (ln != 16'hFFFF) ln = ln + 1;
            col = 16'd1;
         end else if (col != 16'hFFFF) col = col + 1;
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) token_q.push_back(step_q[i]);
   endtask

   initial begin
      fail_count = 0;
      lex_reset();
   end

   assign pending = token_q.size();

   always @(posedge clock) begin
      tok_beat_type got, want;
      if (!reset && req_valid && !req_stall) predict_beat(req_char_code, req_end_of_stream);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_token_kind; got.txt = rsp_is_text; got.ch = rsp_text_char;
         got.done = rsp_token_done; got.val = rsp_int_value; got.ovf = rsp_value_overflow;
         got.line = rsp_start_line; got.col = rsp_start_column; got.err = rsp_error_code;
         got.last = rsp_last;
         if (token_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: kind %0d text %0b char %h", got.kind,
                        got.txt, got.ch);
         end else begin
            want = token_q.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: exp k%0d t%0b c%h d%0b v%h o%0b l%0d c%0d e%0d z%0b",
                           want.kind, want.txt, want.ch, want.done, want.val, want.ovf,
                           want.line, want.col, want.err, want.last,
                           "\n          got k%0d t%0b c%h d%0b v%h o%0b l%0d c%0d e%0d z%0b",
                           got.kind, got.txt, got.ch, got.done, got.val, got.ovf,
                           got.line, got.col, got.err, got.last);
            end
         end
      end
   end

endmodule

// ===== sim/sql_query_tokenizer_test.sv =====
// sql_query_tokenizer_test: drives character beats into the tokenizer with bursts,
// gaps and result stalls, and gives the verdict. Depends on
// sql_query_tokenizer and sqt_token_checker.
`timescale 1ns / 1ps

module sql_query_tokenizer_test;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [20:0] req_char_code;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_token_kind;
   logic        rsp_is_text;
   logic [20:0] rsp_text_char;
   logic        rsp_token_done;
   logic [63:0] rsp_int_value;
   logic        rsp_value_overflow;
   logic [15:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [3:0]  rsp_error_code;
   logic        rsp_last;
   int          fail_count;
   int          pending;
   int          beats_sent;
   int          burst_left;
   int          idle_cycles;
   int          stall_left;
   int          stall_mode;

   sql_query_tokenizer uut (.*);

   sqt_token_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // result side stall pattern
   initial begin
      rsp_stall = 0;
      stall_left = 0;
      stall_mode = 0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
         $display("sql_query_tokenizer_test NOT OK");
         $finish;
      end
   end

   task automatic send_beat(logic [20:0] c, logic eos);
      req_valid <= 1;
      req_char_code <= c;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(21'(s[i]), 0);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_beat(21'($urandom_range(0, 21'h1FFFFF)), 0);
         1: send_beat(21'($urandom_range(0, 127)), 0);
         2: send_beat(21'd13, 0);
         default: send_beat(21'($urandom_range(9, 12)), 0);
      endcase
   endtask

   string frags[] = '{"SELECT", "from", "_x9", "b", "e", "x1", "o", "0", "007", "123",
                      "0x1fA", "0b101", "0o17", "0b", "0x", "0b12", "0o78", "b'1010'",
                      "x'fF'", "o'777'", "b''", "x'1g", "'ab''c'", "e'a\\b'", "'a\\b'",
                      "'x\ny'", "1.25", "3.", "1.5e+10", "2E7", "1e", "4.e-", "1.e-x",
                      "/* a /* b */ */", "/*", "-- c\n", "#", ":", "::", "<", "<=", "<<",
                      "<>", ">", ">=", ">>", "|", "||", "||/", "|/", "%&()[]*+,.;@^=~",
                      " ", "\n", "\t", "99999999999999999999", "0xFFFFFFFFFFFFFFFFF",
                      "0B11'", "O'7", "X'", "'q'"};

   initial begin
      bit paused;
      reset = 1;
      req_valid = 0;
      req_char_code = '0;
      req_end_of_stream = 0;
      beats_sent = 0;
      burst_left = 0;
      idle_cycles = 0;
      paused = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      send_text("#\n#\nab 0x1F 1.5e-3 'a''b' ||/");
      send_beat('0, 1);
      send_text("/*/**/*/'");
      send_beat(21'h1FFFFF, 1);

      while (beats_sent < 262) begin
         if (!paused && beats_sent > 150) begin
            paused = 1;
            req_valid <= 0;
            do @(posedge clock); while (pending != 0);
            repeat (4) @(posedge clock);
         end
         case ($urandom_range(0, 19))
            0: send_beat(21'($urandom_range(0, 21'h1FFFFF)), 1);
            1: send_noise();
            2: begin
               send_beat('0, 1);
               send_text("#x\n#y\nz");
            end
            default: begin
               send_text(frags[$urandom_range(0, frags.size() - 1)]);
               if ($urandom_range(0, 1) == 0) send_text(" ");
            end
         endcase
      end
      send_beat('0, 1);
      req_valid <= 0;

      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("sql_query_tokenizer_test OK");
      end else begin
         $display("sql_query_tokenizer_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sqt_pkg.sv
sv/sqt_core.sv
sv/sqt_rsp_buf.sv
sv/sql_query_tokenizer.sv
sim/sqt_token_checker.sv
sim/sql_query_tokenizer_test.sv
